/* sv/crs_pkg.sv */
// Shared types, constants and helper functions for the closest rank selector.
`default_nettype none
package crs_pkg;

	localparam int RANK_W = 16;
	localparam int DIM_W  = 9;
	localparam int T_W    = 7;
	localparam int POS_W  = 10;
	localparam int HOP_W  = 10;
	localparam int CNT_W  = $clog2(RANK_W);

	localparam int MAX_CANDIDATES = 1024;
	localparam int MAX_DIM        = 256;
	localparam int POS_LIMIT      = (MAX_CANDIDATES < 1024) ? MAX_CANDIDATES - 1 : 1023;
	localparam int HOP_LIMIT      = 1023;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_T  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Z = 3'd6;

	typedef struct packed {
		logic [DIM_W-1:0] nx;
		logic [DIM_W-1:0] ny;
		logic [DIM_W-1:0] nz;
		logic [T_W-1:0]   nt;
		logic             wrap_x;
		logic             wrap_y;
		logic             wrap_z;
		logic             dims_zero;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [RANK_W-1:0] dividend;
		logic [DIM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RANK_W-1:0] quotient;
		logic [DIM_W-1:0]  remainder;
	} div_rsp_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		clamp_dim = (32'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : d;
	endfunction

	// Distance along one axis; a torus axis takes the shorter way around.
	function automatic logic [DIM_W-1:0] axis_hops(input logic [DIM_W-1:0] a,
			input logic [DIM_W-1:0] b, input logic [DIM_W-1:0] dim, input logic wrap);
		logic [DIM_W-1:0] d;
		logic [DIM_W-1:0] alt;
		d   = (a > b) ? a - b : b - a;
		alt = dim - d;
		if (wrap && dim >= d && alt < d) begin
			d = alt;
		end
		axis_hops = d;
	endfunction

endpackage
`default_nettype wire

/* sv/closest_rank_select_top.sv */
// Closest rank selector: sequencer, hop computation and running minimum.
// One candidate at a time: six 16-bit divisions (t, x, y digits of both ranks) on one
// shared divider, then a hop step and an update step; in_ready returns only after the
// update, so a new candidate is not taken before the last one is through.
// A last candidate's result is valid in the same cycle that in_ready returns.
// in_ready is low while an item is in work or a finished result cannot yet be stored.
// Reset clears the list state and the output valid; registers return to 1 for every field.
`default_nettype none
module closest_rank_select_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [crs_pkg::RANK_W-1:0]    my_rank,
	input  wire logic [crs_pkg::RANK_W-1:0]    candidate_rank,
	input  wire logic                          last_candidate,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [crs_pkg::POS_W-1:0]     closest_index,
	output      logic [crs_pkg::HOP_W-1:0]     min_hops,
	output      logic                          found,
	output      logic                          range_error,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [crs_pkg::DIM_W-1:0]     cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WAIT = 2'd1;
	localparam logic [1:0] S_HOP  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	localparam logic [1:0] PH_T = 2'd0;
	localparam logic [1:0] PH_X = 2'd1;
	localparam logic [1:0] PH_Y = 2'd2;

	crs_pkg::cfg_t     cfg;
	crs_pkg::div_req_t div_req;
	crs_pkg::div_rsp_t div_rsp;

	logic [1:0]                  state_q;
	logic [1:0]                  phase_q;
	logic                        side_q;
	logic [crs_pkg::RANK_W-1:0]  cand_q;
	logic                        last_q;
	logic                        err_q;
	logic [crs_pkg::DIM_W-1:0]   x_q [2];
	logic [crs_pkg::DIM_W-1:0]   y_q [2];
	logic [crs_pkg::DIM_W-1:0]   z_q [2];
	logic [crs_pkg::HOP_W-1:0]   hops_q;
	logic [crs_pkg::HOP_W-1:0]   best_hops_q;
	logic [crs_pkg::POS_W-1:0]   best_pos_q;
	logic [crs_pkg::POS_W-1:0]   pos_q;
	logic                        have_best_q;
	logic                        saw_error_q;
	logic                        out_valid_q;
	logic [crs_pkg::POS_W-1:0]   out_index_q;
	logic [crs_pkg::HOP_W-1:0]   out_hops_q;
	logic                        out_found_q;
	logic                        out_err_q;

	logic                        accept;
	logic                        div_last;
	logic [1:0]                  nxt_phase;
	logic                        nxt_side;
	logic [crs_pkg::DIM_W-1:0]   y0, y1, z0, z1;
	logic [crs_pkg::HOP_W:0]     hop_sum;
	logic                        take;
	logic                        out_free;
	logic                        leave_upd;
	logic [crs_pkg::HOP_W-1:0]   best_hops_n;
	logic [crs_pkg::POS_W-1:0]   best_pos_n;
	logic                        have_best_n;
	logic                        saw_error_n;

	crs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	crs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_last  = side_q && (phase_q == PH_Y);

	// Each rank is taken apart digit by digit: divide by dim_t, then dim_x, then dim_y.
	always_comb begin
		if (phase_q == PH_Y) begin
			nxt_phase = PH_T;
			nxt_side  = 1'b1;
		end else begin
			nxt_phase = phase_q + 2'd1;
			nxt_side  = side_q;
		end
		div_req.start = accept || (state_q == S_WAIT && div_rsp.done && !div_last);
		if (accept) begin
			div_req.dividend = my_rank;
			div_req.divisor  = {{(crs_pkg::DIM_W - crs_pkg::T_W){1'b0}}, cfg.nt};
		end else begin
			div_req.dividend = (nxt_phase == PH_T) ? cand_q : div_rsp.quotient;
			unique case (nxt_phase)
				PH_T:    div_req.divisor = {{(crs_pkg::DIM_W - crs_pkg::T_W){1'b0}}, cfg.nt};
				PH_X:    div_req.divisor = cfg.nx;
				default: div_req.divisor = cfg.ny;
			endcase
		end
	end

	// A flat y axis puts every rank in the y = 0, z = 0 plane.
	always_comb begin
		y0 = (cfg.ny == crs_pkg::DIM_W'(1)) ? '0 : y_q[0];
		y1 = (cfg.ny == crs_pkg::DIM_W'(1)) ? '0 : y_q[1];
		z0 = (cfg.ny == crs_pkg::DIM_W'(1)) ? '0 : z_q[0];
		z1 = (cfg.ny == crs_pkg::DIM_W'(1)) ? '0 : z_q[1];
		hop_sum = (crs_pkg::HOP_W+1)'(crs_pkg::axis_hops(x_q[0], x_q[1], cfg.nx, cfg.wrap_x))
			+ (crs_pkg::HOP_W+1)'(crs_pkg::axis_hops(y0, y1, cfg.ny, cfg.wrap_y))
			+ (crs_pkg::HOP_W+1)'(crs_pkg::axis_hops(z0, z1, cfg.nz, cfg.wrap_z));
	end

	always_comb begin
		take        = !err_q && (!have_best_q || hops_q < best_hops_q);
		best_hops_n = take ? hops_q : best_hops_q;
		best_pos_n  = take ? pos_q : best_pos_q;
		have_best_n = have_best_q || take;
		saw_error_n = saw_error_q || err_q;
		out_free    = !out_valid_q || out_ready;
		leave_upd   = (state_q == S_UPD) && (!last_q || out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_T;
			side_q      <= 1'b0;
			err_q       <= 1'b0;
			best_hops_q <= '0;
			best_pos_q  <= '0;
			pos_q       <= '0;
			have_best_q <= 1'b0;
			saw_error_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (leave_upd && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WAIT;
						phase_q <= PH_T;
						side_q  <= 1'b0;
						err_q   <= cfg.dims_zero;
					end
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						// The last quotient is the z digit; it must stay below dim_z.
						if (phase_q == PH_Y &&
								div_rsp.quotient >= crs_pkg::RANK_W'(cfg.nz)) begin
							err_q <= 1'b1;
						end
						phase_q <= nxt_phase;
						side_q  <= nxt_side;
						if (div_last) begin
							state_q <= S_HOP;
						end
					end
				end
				S_HOP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (leave_upd) begin
						state_q <= S_IDLE;
						if (last_q) begin
							best_hops_q <= '0;
							best_pos_q  <= '0;
							pos_q       <= '0;
							have_best_q <= 1'b0;
							saw_error_q <= 1'b0;
						end else begin
							best_hops_q <= best_hops_n;
							best_pos_q  <= best_pos_n;
							have_best_q <= have_best_n;
							saw_error_q <= saw_error_n;
							if (32'(pos_q) < crs_pkg::POS_LIMIT) begin
								pos_q <= pos_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= candidate_rank;
			last_q <= last_candidate;
		end
		if (state_q == S_WAIT && div_rsp.done) begin
			if (phase_q == PH_X) begin
				x_q[side_q] <= div_rsp.remainder;
			end
			if (phase_q == PH_Y) begin
				y_q[side_q] <= div_rsp.remainder;
				z_q[side_q] <= div_rsp.quotient[crs_pkg::DIM_W-1:0];
			end
		end
		if (state_q == S_HOP) begin
			hops_q <= (hop_sum > (crs_pkg::HOP_W+1)'(crs_pkg::HOP_LIMIT)) ?
				crs_pkg::HOP_W'(crs_pkg::HOP_LIMIT) : hop_sum[crs_pkg::HOP_W-1:0];
		end
		if (leave_upd && last_q) begin
			out_index_q <= best_pos_n;
			out_hops_q  <= best_hops_n;
			out_found_q <= have_best_n;
			out_err_q   <= saw_error_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign closest_index = out_index_q;
	assign min_hops      = out_hops_q;
	assign found         = out_found_q;
	assign range_error   = out_err_q;

	// A result appears only as a last candidate leaves the update step.
	a_out_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_UPD && last_q))
		else $error("result raised outside the update of a last candidate");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_WAIT)
		else $error("divider finished outside the wait state");

	// The list position stops at its limit.
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= crs_pkg::POS_LIMIT)
		else $error("list position beyond its limit");

	// Without a best candidate the kept hop count and position stay zero.
	a_empty_best: assert property (@(posedge clk) disable iff (!arst_n)
		!have_best_q |-> (best_hops_q == '0 && best_pos_q == '0))
		else $error("best values held without a best candidate");

endmodule
`default_nettype wire

/* sv/crs_cfg.sv */
// Configuration register bank with dimension clamping.
`default_nettype none
module crs_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [crs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [crs_pkg::DIM_W-1:0]      wr_data,
	output crs_pkg::cfg_t                       cfg
);

	logic [crs_pkg::DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;
	logic [crs_pkg::T_W-1:0]   dim_t_q;
	logic                      wrap_x_q, wrap_y_q, wrap_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q  <= crs_pkg::DIM_W'(1);
			dim_y_q  <= crs_pkg::DIM_W'(1);
			dim_z_q  <= crs_pkg::DIM_W'(1);
			dim_t_q  <= crs_pkg::T_W'(1);
			wrap_x_q <= 1'b1;
			wrap_y_q <= 1'b1;
			wrap_z_q <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				crs_pkg::CFG_DIM_X:  dim_x_q  <= wr_data;
				crs_pkg::CFG_DIM_Y:  dim_y_q  <= wr_data;
				crs_pkg::CFG_DIM_Z:  dim_z_q  <= wr_data;
				crs_pkg::CFG_DIM_T:  dim_t_q  <= wr_data[crs_pkg::T_W-1:0];
				crs_pkg::CFG_WRAP_X: wrap_x_q <= wr_data[0];
				crs_pkg::CFG_WRAP_Y: wrap_y_q <= wr_data[0];
				crs_pkg::CFG_WRAP_Z: wrap_z_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.nx        = crs_pkg::clamp_dim(dim_x_q);
		cfg.ny        = crs_pkg::clamp_dim(dim_y_q);
		cfg.nz        = crs_pkg::clamp_dim(dim_z_q);
		cfg.nt        = dim_t_q;
		cfg.wrap_x    = wrap_x_q;
		cfg.wrap_y    = wrap_y_q;
		cfg.wrap_z    = wrap_z_q;
		cfg.dims_zero = (dim_x_q == '0) || (dim_y_q == '0) || (dim_z_q == '0) ||
			(dim_t_q == '0);
	end

endmodule
`default_nettype wire

/* sv/crs_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module crs_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  crs_pkg::div_req_t  req,
	output crs_pkg::div_rsp_t  rsp
);

	logic [crs_pkg::RANK_W-1:0] quo_q;
	logic [crs_pkg::DIM_W-1:0]  rem_q;
	logic [crs_pkg::DIM_W-1:0]  div_q;
	logic [crs_pkg::CNT_W-1:0]  cnt_q;
	logic                       run_q;
	logic                       done_q;

	logic [crs_pkg::DIM_W:0]    trial;
	logic [crs_pkg::DIM_W:0]    diff;
	logic                       ge;
	logic [crs_pkg::DIM_W-1:0]  rem_n;

	always_comb begin
		trial = {rem_q, quo_q[crs_pkg::RANK_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
		rem_n = ge ? diff[crs_pkg::DIM_W-1:0] : trial[crs_pkg::DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !req.start &&
				(cnt_q == crs_pkg::CNT_W'(crs_pkg::RANK_W - 1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == crs_pkg::CNT_W'(crs_pkg::RANK_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[crs_pkg::RANK_W-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

/* verif/crs_checker.sv */
// Checker for the closest rank selector: predicts each list result and compares what comes out.
module crs_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [crs_pkg::RANK_W-1:0]    my_rank,
	input  wire logic [crs_pkg::RANK_W-1:0]    candidate_rank,
	input  wire logic                          last_candidate,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [crs_pkg::POS_W-1:0]     closest_index,
	input  wire logic [crs_pkg::HOP_W-1:0]     min_hops,
	input  wire logic                          found,
	input  wire logic                          range_error,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [crs_pkg::DIM_W-1:0]     cfg_data,
	output int                                 mismatches,
	output int                                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [crs_pkg::POS_W-1:0] pos;
		logic [crs_pkg::HOP_W-1:0] hops;
		logic                      hit;
		logic                      bad;
	} list_result_t;

	typedef struct packed {
		logic [8:0] x;
		logic [8:0] y;
		logic [8:0] z;
	} coord_t;

	// Register copies.
	logic [crs_pkg::DIM_W-1:0] size_x, size_y, size_z;
	logic [crs_pkg::T_W-1:0]   size_t;
	logic                      torus_x, torus_y, torus_z;

	// Running minimum of the current list.
	logic [crs_pkg::HOP_W-1:0] low_hops;
	logic [crs_pkg::POS_W-1:0] low_pos;
	logic [crs_pkg::POS_W-1:0] list_pos;
	logic                      any_hit;
	logic                      any_bad;

	list_result_t pending_results[$];
	int fail_count = 0;
	int queued = 0;

	assign mismatches  = fail_count;
	assign outstanding = queued;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
		end
	endtask

	function automatic longint unsigned clip_dim(input logic [crs_pkg::DIM_W-1:0] d);
		return (d > crs_pkg::MAX_DIM) ? longint'(crs_pkg::MAX_DIM) : longint'(d);
	endfunction

	// Digits of a rank; with a single y plane the y and z digits are forced to zero.
	function automatic coord_t place(input longint unsigned r, input longint unsigned nx,
			input longint unsigned ny, input longint unsigned nt);
		coord_t c;
		c.x = 9'((r % (nt * nx)) / nt);
		if (ny > 1) begin
			c.y = 9'((r % (nt * nx * ny)) / (nt * nx));
			c.z = 9'(r / (nt * nx * ny));
		end else begin
			c.y = '0;
			c.z = '0;
		end
		return c;
	endfunction

	function automatic longint unsigned axis_dist(input longint unsigned a,
			input longint unsigned b, input longint unsigned span, input logic ring);
		longint unsigned d;
		d = (a > b) ? a - b : b - a;
		if (ring && span >= d && span - d < d) begin
			d = span - d;
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		longint unsigned nx, ny, nz, nt, total, h;
		coord_t a, b;
		list_result_t want;
		if (!arst_n) begin
			size_x = 1;
			size_y = 1;
			size_z = 1;
			size_t = 1;
			torus_x = 1'b1;
			torus_y = 1'b1;
			torus_z = 1'b1;
			low_hops = '0;
			low_pos = '0;
			list_pos = '0;
			any_hit = 1'b0;
			any_bad = 1'b0;
			pending_results.delete();
			queued <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					crs_pkg::CFG_DIM_X: size_x = cfg_data;
					crs_pkg::CFG_DIM_Y: size_y = cfg_data;
					crs_pkg::CFG_DIM_Z: size_z = cfg_data;
					crs_pkg::CFG_DIM_T: size_t = cfg_data[crs_pkg::T_W-1:0];
					crs_pkg::CFG_WRAP_X: torus_x = cfg_data[0];
					crs_pkg::CFG_WRAP_Y: torus_y = cfg_data[0];
					crs_pkg::CFG_WRAP_Z: torus_z = cfg_data[0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result index %0d hops %0d with none pending",
						closest_index, min_hops));
				end else begin
					want = pending_results.pop_front();
					check_field("closest_index", 16'(closest_index), 16'(want.pos));
					check_field("min_hops", 16'(min_hops), 16'(want.hops));
					check_field("found", 16'(found), 16'(want.hit));
					check_field("range_error", 16'(range_error), 16'(want.bad));
				end
			end

			if (in_valid && in_ready) begin
				nx = clip_dim(size_x);
				ny = clip_dim(size_y);
				nz = clip_dim(size_z);
				nt = longint'(size_t);
				total = nx * ny * nz * nt;
				// An out-of-range candidate still uses up a list position.
				if (total == 0 || my_rank >= total || candidate_rank >= total) begin
					any_bad = 1'b1;
				end else begin
					a = place(my_rank, nx, ny, nt);
					b = place(candidate_rank, nx, ny, nt);
					h = axis_dist(a.x, b.x, nx, torus_x) + axis_dist(a.y, b.y, ny, torus_y)
						+ axis_dist(a.z, b.z, nz, torus_z);
					if (h > crs_pkg::HOP_LIMIT) begin
						h = crs_pkg::HOP_LIMIT;
					end
					if (!any_hit || h < low_hops) begin
						low_hops = h[crs_pkg::HOP_W-1:0];
						low_pos = list_pos;
						any_hit = 1'b1;
					end
				end
				if (list_pos < crs_pkg::POS_LIMIT) begin
					list_pos = list_pos + 1'b1;
				end
				if (last_candidate) begin
					want.pos  = any_hit ? low_pos : '0;
					want.hops = any_hit ? low_hops : '0;
					want.hit  = any_hit;
					want.bad  = any_bad;
					pending_results.push_back(want);
					low_hops = '0;
					low_pos = '0;
					list_pos = '0;
					any_hit = 1'b0;
					any_bad = 1'b0;
				end
			end
			queued <= pending_results.size();
		end
	end

endmodule

/* verif/tb_closest_rank_select_top.sv */
// Testbench top for the closest rank selector: stimulus, register setup and final verdict.
module tb_closest_rank_select_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [crs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int SETTLE_CYCLES = 120;
	localparam int RANDOM_ITEMS = 600;
	localparam int CALM_AFTER = 540;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [crs_pkg::RANK_W-1:0] my_rank = '0;
	logic [crs_pkg::RANK_W-1:0] candidate_rank = '0;
	logic last_candidate = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [crs_pkg::POS_W-1:0] closest_index;
	logic [crs_pkg::HOP_W-1:0] min_hops;
	logic found;
	logic range_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [crs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [crs_pkg::DIM_W-1:0] cfg_data = '0;
	int mismatches;
	int outstanding;

	// No idling on either side once this is set.
	logic calm = 1'b0;
	// Number of valid ranks under the current registers, capped at the rank space.
	longint unsigned rank_span = 1;

	closest_rank_select_top dut (.*);
	crs_checker watch (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : sink
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// Wait for every pending result, then let the block finish any item in flight.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [crs_pkg::CFG_IDX_W-1:0] idx,
			input logic [crs_pkg::DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input int dx, input int dy, input int dz, input int dt,
			input logic wx, input logic wy, input logic wz);
		longint unsigned total;
		settle();
		write_reg(crs_pkg::CFG_DIM_X, 9'(dx));
		write_reg(crs_pkg::CFG_DIM_Y, 9'(dy));
		write_reg(crs_pkg::CFG_DIM_Z, 9'(dz));
		write_reg(crs_pkg::CFG_DIM_T, 9'(dt));
		// Upper data bits of the wrap registers are junk the block must drop.
		write_reg(crs_pkg::CFG_WRAP_X, {8'($urandom_range(0, 255)), wx});
		write_reg(crs_pkg::CFG_WRAP_Y, {8'($urandom_range(0, 255)), wy});
		write_reg(crs_pkg::CFG_WRAP_Z, {8'($urandom_range(0, 255)), wz});
		cfg_valid <= 1'b0;
		total = longint'((dx > crs_pkg::MAX_DIM) ? crs_pkg::MAX_DIM : (dx & 511))
			* longint'((dy > crs_pkg::MAX_DIM) ? crs_pkg::MAX_DIM : (dy & 511))
			* longint'((dz > crs_pkg::MAX_DIM) ? crs_pkg::MAX_DIM : (dz & 511))
			* longint'(dt & 127);
		rank_span = (total > 65536) ? 65536 : total;
	endtask

	task automatic send_candidate(input logic [crs_pkg::RANK_W-1:0] me,
			input logic [crs_pkg::RANK_W-1:0] cand, input logic fin);
		int bursts;
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			bursts = $urandom_range(1, 12);
			repeat (bursts) repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		my_rank <= me;
		candidate_rank <= cand;
		last_candidate <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [crs_pkg::RANK_W-1:0] pick_rank(input int bad_pct);
		if (rank_span == 0 || $urandom_range(0, 99) < bad_pct) begin
			return 16'($urandom_range(0, 65535));
		end
		return 16'($urandom_range(0, 32'(rank_span - 1)));
	endfunction

	initial begin : stimulus
		int sent, phase_items, list_len, mode, k;
		logic [crs_pkg::RANK_W-1:0] me, cand;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Registers at reset: a single node, so only rank 0 is valid.
		send_candidate(16'd0, 16'd0, 1'b1);
		// Each candidate pair holds an out-of-range rank: nothing found, error flagged.
		send_candidate(16'd0, 16'd1, 1'b0);
		send_candidate(16'd1, 16'd0, 1'b1);

		// Torus shortcut, a tie kept at the earlier position, a skipped rank, then a zero hop.
		apply_setting(8, 4, 4, 2, 1'b1, 1'b1, 1'b1);
		send_candidate(16'd0, 16'd14, 1'b0);
		send_candidate(16'd0, 16'd2, 1'b0);
		send_candidate(16'd0, 16'd300, 1'b0);
		send_candidate(16'd0, 16'd1, 1'b1);

		apply_setting(8, 4, 4, 2, 1'b0, 1'b0, 1'b0);
		send_candidate(16'd0, 16'd14, 1'b1);

		// Oversized x is taken as the maximum; corners of the rank space.
		apply_setting(511, 256, 256, 1, 1'b0, 1'b0, 1'b0);
		send_candidate(16'hFFFF, 16'd0, 1'b0);
		send_candidate(16'd0, 16'hFFFF, 1'b1);

		// A single y plane drops the y and z digits even with several z planes.
		apply_setting(4, 1, 8, 1, 1'b1, 1'b1, 1'b1);
		send_candidate(16'd0, 16'd20, 1'b0);
		send_candidate(16'd3, 16'd5, 1'b1);

		// Zero dimensions make every rank out of range.
		apply_setting(4, 4, 4, 0, 1'b1, 1'b1, 1'b1);
		send_candidate(16'd0, 16'd0, 1'b1);
		apply_setting(0, 2, 2, 2, 1'b1, 1'b0, 1'b1);
		send_candidate(16'd3, 16'd3, 1'b1);

		// The high bits of a dim_t write are dropped, and the spare index does nothing.
		apply_setting(2, 2, 2, 257, 1'b1, 1'b1, 1'b1);
		write_reg(CFG_SPARE, 9'h1FF);
		cfg_valid <= 1'b0;
		send_candidate(16'd0, 16'd7, 1'b0);
		send_candidate(16'd7, 16'd0, 1'b0);
		send_candidate(16'd5, 16'd5, 1'b1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 11);
			if (mode <= 5) begin
				apply_setting($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(1, 4), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else if (mode <= 7) begin
				apply_setting($urandom_range(128, 256), $urandom_range(128, 256),
					$urandom_range(1, 256), $urandom_range(1, 64), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (mode == 8) begin
				apply_setting($urandom_range(1, 32), 1, $urandom_range(2, 64),
					$urandom_range(1, 4), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else if (mode == 9) begin
				apply_setting($urandom_range(257, 511), $urandom_range(1, 3),
					$urandom_range(257, 511), 1, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (mode == 10) begin
				if ($urandom_range(0, 1) == 0) begin
					apply_setting(256, 256, 256, 64, 1'b1, 1'b1, 1'b1);
				end else begin
					apply_setting(1, 1, 1, 1, 1'b0, 1'b0, 1'b0);
				end
			end else begin
				k = $urandom_range(0, 3);
				apply_setting((k == 0) ? 0 : 4, (k == 1) ? 0 : 4, (k == 2) ? 0 : 4,
					(k == 3) ? 0 : 2, 1'b1, 1'b0, 1'b1);
			end

			phase_items = 0;
			while (phase_items < 45 && sent < RANDOM_ITEMS) begin
				calm = (sent >= CALM_AFTER);
				list_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(1, 6);
				me = pick_rank(10);
				for (k = 0; k < list_len; k++) begin
					// Now and then the reference rank moves within a list.
					if ($urandom_range(0, 19) == 0) begin
						me = pick_rank(10);
					end
					case ($urandom_range(0, 9))
						0: cand = me;
						1: cand = me ^ (16'd1 << $urandom_range(0, 15));
						default: cand = pick_rank(15);
					endcase
					send_candidate(me, cand, k == list_len - 1);
					sent++;
					phase_items++;
				end
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
